// ===== rtl/imu_offset_calibrator_top_defines.svh =====
// Assertion helpers shared by the calibrator checks.
`ifndef IMU_OFFSET_CALIBRATOR_TOP_DEFINES_SVH
`define IMU_OFFSET_CALIBRATOR_TOP_DEFINES_SVH

// Check a property at every edge outside reset.
`define IOC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define IOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ioc_pkg.sv =====
package ioc_pkg;

  localparam int NUM_AXES = 6;

  typedef logic signed [15:0] ioc_word_t;
  typedef logic signed [31:0] ioc_sum_t;

  // Item kinds
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Axis codes and scaling
  localparam logic [2:0] AXIS_AZ    = 3'd2;
  localparam logic [2:0] NUM_ACCEL  = 3'd3;
  localparam logic [2:0] AXIS_LAST  = 3'(NUM_AXES - 1);
  localparam logic [1:0] ACCEL_SHIFT = 2'd3;
  localparam logic [1:0] GYRO_SHIFT  = 2'd2;
  localparam ioc_sum_t   ACCEL_ONE_G = 32'sd16384;

  // Reset values of the configuration registers
  localparam logic [7:0]  LOOP_COUNT_RST = 8'd6;
  localparam logic [15:0] SPL_RST        = 16'd100;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LOOP_COUNT    = 3'd0,
    REG_SAMPLES       = 3'd1,
    REG_START_ACCEL_X = 3'd2,
    REG_START_ACCEL_Y = 3'd3,
    REG_START_ACCEL_Z = 3'd4,
    REG_START_GYRO_X  = 3'd5,
    REG_START_GYRO_Y  = 3'd6,
    REG_START_GYRO_Z  = 3'd7
  } ioc_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DSTART = 4'b0010,
    ST_DWAIT  = 4'b0100,
    ST_EMIT   = 4'b1000
  } ioc_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic seed;
    logic accum;
    logic div_start;
    logic commit;
    logic round_close;
    logic load_out;
  } ioc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic running;
    logic last_sample;
    logic div_done;
    logic axis_last;
    logic out_free;
  } ioc_stat_t;

  // Scale shift of an axis: accel by 8, gyro by 4
  function automatic logic [1:0] axis_shift(input logic [2:0] axis);
    return (axis < NUM_ACCEL) ? ACCEL_SHIFT : GYRO_SHIFT;
  endfunction

  // Signed divide by a power of two, truncating toward zero
  function automatic ioc_sum_t sdiv_pow2(input ioc_sum_t x, input logic [1:0] sh);
    ioc_sum_t bias;
    bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// ===== rtl/ioc_ifs.sv =====
interface ioc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] sample_ax;
  logic signed [15:0] sample_ay;
  logic signed [15:0] sample_az;
  logic signed [15:0] sample_gx;
  logic signed [15:0] sample_gy;
  logic signed [15:0] sample_gz;

  modport source (
    output valid, func, sample_ax, sample_ay, sample_az, sample_gx, sample_gy, sample_gz,
    input  ready
  );
  modport sink (
    input  valid, func, sample_ax, sample_ay, sample_az, sample_gx, sample_gy, sample_gz,
    output ready
  );
endinterface

interface ioc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] apply_accel_x;
  logic signed [15:0] apply_accel_y;
  logic signed [15:0] apply_accel_z;
  logic signed [15:0] apply_gyro_x;
  logic signed [15:0] apply_gyro_y;
  logic signed [15:0] apply_gyro_z;
  logic               done_res;

  modport source (
    output valid, apply_accel_x, apply_accel_y, apply_accel_z,
    output apply_gyro_x, apply_gyro_y, apply_gyro_z, done_res,
    input  ready
  );
  modport sink (
    input  valid, apply_accel_x, apply_accel_y, apply_accel_z,
    input  apply_gyro_x, apply_gyro_y, apply_gyro_z, done_res,
    output ready
  );
endinterface

// ===== rtl/ioc_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle
module ioc_div import ioc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  ioc_sum_t    dividend,
  input  logic [15:0] divisor,
  output ioc_sum_t    quot,
  output logic        done
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] acc_r;
  logic [15:0] rem_r;
  logic [15:0] den_r;
  logic        neg_r;
  ioc_sum_t    quot_r;
  logic        done_r;

  logic [16:0] rem_sh;
  logic [16:0] rem_diff;
  logic        q_bit;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh   = {rem_r, acc_r[31]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
  end

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the iteration; last step restores the sign
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend[31] ? 32'(-dividend) : dividend;
      neg_r <= dividend[31];
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        quot_r <= neg_r ? -ioc_sum_t'(acc_r) : ioc_sum_t'(acc_r);
      end else begin
        rem_r <= q_bit ? rem_diff[15:0] : rem_sh[15:0];
        acc_r <= {acc_r[30:0], q_bit};
      end
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

// ===== rtl/ioc_ctrl.sv =====
// Sequencer: accept items, step the six means, hand off results
module ioc_ctrl import ioc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_func,
  output logic      in_ready,
  input  ioc_stat_t stat,
  output ioc_cmd_t  cmd
);

  ioc_state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            cmd.seed  = 1'b1;
            state_nxt = ST_EMIT;
          end else if (stat.running) begin
            cmd.accum = 1'b1;
            if (stat.last_sample) begin
              state_nxt = ST_DSTART;
            end
          end
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          if (stat.axis_last) begin
            cmd.round_close = 1'b1;
            state_nxt       = ST_EMIT;
          end else begin
            state_nxt = ST_DSTART;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/ioc_datapath.sv =====
// Registers, sums, estimates, shared divider and output register
module ioc_datapath import ioc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  ioc_word_t   sample [NUM_AXES],
  input  ioc_cmd_t    cmd,
  output ioc_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output ioc_word_t   apply [NUM_AXES],
  output logic        done_res
);

  // Configuration
  logic [7:0]  loop_r;
  logic [15:0] spl_r;
  ioc_word_t   start_r [NUM_AXES];

  // Calibration state
  ioc_sum_t    sums_r [NUM_AXES];
  ioc_word_t   est_r  [NUM_AXES];
  logic [15:0] cnt_r;
  logic [7:0]  round_r;
  logic        running_r;
  logic        done_r;
  logic [2:0]  axis_r;

  // Output register
  logic        out_valid_r;
  ioc_word_t   apply_r [NUM_AXES];
  logic        out_done_r;

  logic [15:0] spl_eff;
  logic [15:0] cnt_inc;
  logic [7:0]  round_inc;
  logic        round_end;
  ioc_sum_t    div_q;
  logic        div_done;
  ioc_sum_t    corr;
  ioc_word_t   est_nxt;
  ioc_sum_t    seed_q [NUM_AXES];

  ioc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sums_r[axis_r]),
    .divisor  (spl_eff),
    .quot     (div_q),
    .done     (div_done)
  );

  // Counters, round end and the correction of the current axis
  always_comb begin
    spl_eff   = (spl_r == '0) ? 16'd1 : spl_r;
    cnt_inc   = cnt_r + 16'd1;
    round_inc = round_r + 8'd1;
    round_end = (round_inc >= loop_r);
    if (axis_r == AXIS_AZ) begin
      corr    = sdiv_pow2(ACCEL_ONE_G - div_q, ACCEL_SHIFT);
      est_nxt = est_r[axis_r] + corr[15:0];
    end else begin
      corr    = sdiv_pow2(div_q, axis_shift(axis_r));
      est_nxt = est_r[axis_r] - corr[15:0];
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      seed_q[k] = sdiv_pow2(32'(start_r[k]), axis_shift(3'(k)));
    end
  end

  always_comb begin
    stat.running     = running_r;
    stat.last_sample = (cnt_inc >= spl_eff);
    stat.div_done    = div_done;
    stat.axis_last   = (axis_r == AXIS_LAST);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r <= LOOP_COUNT_RST;
      spl_r  <= SPL_RST;
      for (int k = 0; k < NUM_AXES; k++) begin
        start_r[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (ioc_reg_t'(cfg_index))
        REG_LOOP_COUNT:    loop_r     <= cfg_wdata[7:0];
        REG_SAMPLES:       spl_r      <= cfg_wdata;
        REG_START_ACCEL_X: start_r[0] <= cfg_wdata;
        REG_START_ACCEL_Y: start_r[1] <= cfg_wdata;
        REG_START_ACCEL_Z: start_r[2] <= cfg_wdata;
        REG_START_GYRO_X:  start_r[3] <= cfg_wdata;
        REG_START_GYRO_Y:  start_r[4] <= cfg_wdata;
        REG_START_GYRO_Z:  start_r[5] <= cfg_wdata;
      endcase
    end
  end

  // Seed, accumulate, commit each mean, close the round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        sums_r[k] <= '0;
        est_r[k]  <= '0;
      end
      cnt_r     <= '0;
      round_r   <= '0;
      running_r <= 1'b0;
      done_r    <= 1'b0;
      axis_r    <= '0;
    end else begin
      if (cmd.seed) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          sums_r[k] <= '0;
          est_r[k]  <= seed_q[k][15:0];
        end
        cnt_r     <= '0;
        round_r   <= '0;
        running_r <= (loop_r != '0);
        done_r    <= (loop_r == '0);
      end
      if (cmd.accum) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          sums_r[k] <= sums_r[k] + 32'(sample[k]);
        end
        cnt_r  <= cnt_inc;
        axis_r <= '0;
      end
      if (cmd.commit) begin
        est_r[axis_r]  <= est_nxt;
        sums_r[axis_r] <= '0;
        axis_r         <= axis_r + 3'd1;
      end
      if (cmd.round_close) begin
        cnt_r     <= '0;
        round_r   <= round_inc;
        running_r <= !round_end;
        done_r    <= round_end;
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        apply_r[k] <= est_r[k] <<< axis_shift(3'(k));
      end
      out_done_r <= done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign apply     = apply_r;
  assign done_res  = out_done_r;

endmodule

// ===== rtl/imu_offset_calibrator_top.sv =====
// Six-axis inertial offset calibrator.
// in_chan carries one item: func 0 starts a calibration, func 1 is a raw
// sample of three accel and three gyro axes. out_chan carries the offset
// register values to apply and done_res on the final round. cfg_we with
// cfg_index/cfg_wdata writes loop_count, samples_per_loop and the six
// existing offsets, one register per edge.
// A start item goes to the output register once that register is free. A sample
// that does not close a round is taken and gives nothing. The
// sample that closes a round starts six serial divisions on one shared
// divider (per axis: load, quotient bits one by one, sign fix and
// commit), and its result is loaded after the last commit.
// Samples while idle are dropped. One item is in work at a time.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// sums and estimates and leaves the block idle with no result pending.
// A stalled receiver holds the result in the output register; the block
// takes the next item meanwhile and waits only when a new result is due.
module imu_offset_calibrator_top import ioc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ioc_in_if.sink      in_chan,
  ioc_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ioc_cmd_t  cmd;
  ioc_stat_t stat;
  ioc_word_t sample [NUM_AXES];
  ioc_word_t apply  [NUM_AXES];

  // Gather the sample fields
  assign sample[0] = in_chan.sample_ax;
  assign sample[1] = in_chan.sample_ay;
  assign sample[2] = in_chan.sample_az;
  assign sample[3] = in_chan.sample_gx;
  assign sample[4] = in_chan.sample_gy;
  assign sample[5] = in_chan.sample_gz;

  ioc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ioc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample    (sample),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .apply     (apply),
    .done_res  (out_chan.done_res)
  );

  // Spread the result fields
  assign out_chan.apply_accel_x = apply[0];
  assign out_chan.apply_accel_y = apply[1];
  assign out_chan.apply_accel_z = apply[2];
  assign out_chan.apply_gyro_x  = apply[3];
  assign out_chan.apply_gyro_y  = apply[4];
  assign out_chan.apply_gyro_z  = apply[5];

endmodule

// ===== rtl/ioc_checker.sv =====
`include "imu_offset_calibrator_top_defines.svh"

// Port-level checks of the calibrator
module ioc_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] apply_accel_x,
  input logic [15:0] apply_accel_y,
  input logic [15:0] apply_accel_z,
  input logic [15:0] apply_gyro_x,
  input logic [15:0] apply_gyro_y,
  input logic [15:0] apply_gyro_z,
  input logic        done_res
);

  logic [96:0] out_bits;
  logic        in_take;

  assign out_bits = {apply_accel_x, apply_accel_y, apply_accel_z,
                     apply_gyro_x, apply_gyro_y, apply_gyro_z, done_res};
  assign in_take  = in_valid && in_ready;

  // Handshake on the result channel
  `IOC_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `IOC_ASSERT_RUN(a_out_stable, out_valid && !out_ready |=> $stable(out_bits), "result changed")

  // A start item keeps the block busy until its result is loaded
  `IOC_ASSERT_RUN(a_start_busy, in_take && !in_func |=> !in_ready, "item taken in start")

  // A sample never yields a result on the next edge
  `IOC_ASSERT_RUN(a_sample_quiet, in_take && in_func |=> !$rose(out_valid), "early result")

  // Reset leaves the block idle and empty
  `IOC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind imu_offset_calibrator_top ioc_props u_ioc_props (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_func       (in_chan.func),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .apply_accel_x (out_chan.apply_accel_x),
  .apply_accel_y (out_chan.apply_accel_y),
  .apply_accel_z (out_chan.apply_accel_z),
  .apply_gyro_x  (out_chan.apply_gyro_x),
  .apply_gyro_y  (out_chan.apply_gyro_y),
  .apply_gyro_z  (out_chan.apply_gyro_z),
  .done_res      (out_chan.done_res)
);
